[rtl/sphere_cylinder_radius_spring_top_assert.svh]
// Assertion macros for the sphere/cylinder radius spring block.
// Used by the rtl modules; expects clk_i and rst_ni in scope.
`ifndef SPHERE_CYLINDER_RADIUS_SPRING_TOP_ASSERT_SVH
`define SPHERE_CYLINDER_RADIUS_SPRING_TOP_ASSERT_SVH
`ifndef SYNTH
`define SCRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scrs assertion failed");
`define SCRS_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("scrs forbidden condition seen");
`else
`define SCRS_ASSERT(lbl, prop)
`define SCRS_ASSERT_NEVER(lbl, prop)
`endif
`endif

[rtl/scrs_pkg.sv]
// Shared types and constants for the sphere/cylinder radius spring block.
// No dependencies.
package scrs_pkg;
  localparam int unsigned RootW   = 32;
  localparam int unsigned NumW    = 63;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegPushOut = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPullIn  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadius  = 2'd2;

  localparam logic [30:0] RadiusReset = 31'd65536;

  // per-item data that rides along with the arithmetic
  typedef struct packed {
    logic [2:0][31:0] deriv;
    logic [2:0][31:0] ap;
    logic [2:0]       pneg;
    logic             sphere;
    logic             zero;
    logic             dneg;
  } side_t;
endpackage

[rtl/scrs_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on scrs_pkg and the assertion header.
`include "sphere_cylinder_radius_spring_top_assert.svh"
module scrs_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [63:0]                   radicand_i,
  input  scrs_pkg::side_t               side_i,
  output logic                          out_valid_o,
  output logic [scrs_pkg::RootW-1:0]    root_o,
  output scrs_pkg::side_t               side_o
);
  logic                          valid_q [scrs_pkg::RootW];
  logic [63:0]                   rad_q   [scrs_pkg::RootW];
  logic [34:0]                   rem_q   [scrs_pkg::RootW];
  logic [scrs_pkg::RootW-1:0]    root_q  [scrs_pkg::RootW];
  scrs_pkg::side_t               side_q  [scrs_pkg::RootW];

  for (genvar k = 0; k < scrs_pkg::RootW; k++) begin : g_stage
    logic                       v_in;
    logic [63:0]                rad_in;
    logic [34:0]                rem_in, rem_sh, trial;
    logic [scrs_pkg::RootW-1:0] root_in;
    scrs_pkg::side_t            s_in;
    logic [34:0]                rem_d;
    logic [scrs_pkg::RootW-1:0] root_d;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rad_in  = radicand_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = side_q[k-1];
    end

    // remainder stays below 2*root+1, so 33 bits carry it
    assign rem_sh = {rem_in[32:0], rad_in[63:62]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[scrs_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[scrs_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[61:0], 2'b00};
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      side_q[k] <= s_in;
    end
  end

  assign out_valid_o = valid_q[scrs_pkg::RootW-1];
  assign root_o      = root_q[scrs_pkg::RootW-1];
  assign side_o      = side_q[scrs_pkg::RootW-1];

  `SCRS_ASSERT(a_sqrt_rem_bound, out_valid_o |-> rem_q[scrs_pkg::RootW-1] <= (35'(root_o) << 1))
endmodule

[rtl/scrs_div.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on scrs_pkg and the assertion header.
`include "sphere_cylinder_radius_spring_top_assert.svh"
module scrs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [2:0][scrs_pkg::NumW-1:0] num_i,
  input  logic [31:0]                    den_i,
  input  scrs_pkg::side_t                side_i,
  output logic                           out_valid_o,
  output logic [2:0][scrs_pkg::NumW-1:0] quot_o,
  output scrs_pkg::side_t                side_o
);
  logic                           valid_q [scrs_pkg::NumW];
  logic [2:0][scrs_pkg::NumW-1:0] num_q   [scrs_pkg::NumW];
  logic [2:0][31:0]               rem_q   [scrs_pkg::NumW];
  logic [31:0]                    den_q   [scrs_pkg::NumW];
  scrs_pkg::side_t                side_q  [scrs_pkg::NumW];

  for (genvar k = 0; k < scrs_pkg::NumW; k++) begin : g_stage
    logic                           v_in;
    logic [2:0][scrs_pkg::NumW-1:0] num_in, num_d;
    logic [2:0][31:0]               rem_in, rem_d;
    logic [31:0]                    den_in;
    scrs_pkg::side_t                s_in;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign s_in   = side_q[k-1];
    end

    // dividend bits shift out the top, quotient bits shift in the bottom
    always_comb begin
      logic [32:0] rem_sh;
      for (int i = 0; i < 3; i++) begin
        rem_sh = {rem_in[i], num_in[i][scrs_pkg::NumW-1]};
        if (rem_sh >= {1'b0, den_in}) begin
          rem_d[i] = 32'(rem_sh - {1'b0, den_in});
          num_d[i] = {num_in[i][scrs_pkg::NumW-2:0], 1'b1};
        end else begin
          rem_d[i] = rem_sh[31:0];
          num_d[i] = {num_in[i][scrs_pkg::NumW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= num_d;
      rem_q[k]  <= rem_d;
      den_q[k]  <= den_in;
      side_q[k] <= s_in;
    end
  end

  assign out_valid_o = valid_q[scrs_pkg::NumW-1];
  assign quot_o      = num_q[scrs_pkg::NumW-1];
  assign side_o      = side_q[scrs_pkg::NumW-1];

  `SCRS_ASSERT(a_div_rem_bound, out_valid_o && (den_q[scrs_pkg::NumW-1] != 0) |-> (rem_q[scrs_pkg::NumW-1][0] < den_q[scrs_pkg::NumW-1]) && (rem_q[scrs_pkg::NumW-1][1] < den_q[scrs_pkg::NumW-1]) && (rem_q[scrs_pkg::NumW-1][2] < den_q[scrs_pkg::NumW-1]))
endmodule

[rtl/sphere_cylinder_radius_spring_top.sv]
// Top level of the sphere/cylinder radius spring: config registers, front end
// squares, spring factor products and saturating adders. Uses scrs_pkg,
// scrs_isqrt, scrs_div and the assertion header.
//
// One vertex is taken in every clock cycle (busy stays low) and its result
// appears on the result ports flagged by out_strobe_o for one cycle; the
// receiver cannot stall. The pipeline is the 32-stage square root, one root
// bit per stage, and the 63-stage divider, one quotient bit per stage, plus
// eight stages of input capture, squaring, summing, gain select, products,
// dividend sum and output. Configuration writes are taken in any cycle and
// must only be made while no vertex is in flight.
`include "sphere_cylinder_radius_spring_top_assert.svh"
module sphere_cylinder_radius_spring_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [30:0]                   cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  input  logic signed [31:0]            deriv_x_i,
  input  logic signed [31:0]            deriv_y_i,
  input  logic signed [31:0]            deriv_z_i,
  output logic                          out_strobe_o,
  output logic signed [31:0]            new_deriv_x_o,
  output logic signed [31:0]            new_deriv_y_o,
  output logic signed [31:0]            new_deriv_z_o,
  output logic                          on_sphere_o,
  output logic                          zero_distance_o,
  output logic                          saturated_o
);
  // configuration
  logic [30:0] push_q, pull_q, radius_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q   <= '0;
      pull_q   <= '0;
      radius_q <= scrs_pkg::RadiusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        scrs_pkg::RegPushOut: push_q   <= cfg_data_i;
        scrs_pkg::RegPullIn:  pull_q   <= cfg_data_i;
        scrs_pkg::RegRadius:  radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: capture
  logic             v0_q;
  logic [2:0][31:0] pos0_q, der0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    pos0_q <= {pos_z_i, pos_y_i, pos_x_i};
    der0_q <= {deriv_z_i, deriv_y_i, deriv_x_i};
  end

  scrs_pkg::side_t side0;
  always_comb begin
    side0        = '0;
    side0.deriv  = der0_q;
    side0.sphere = !pos0_q[2][31] && (pos0_q[2] != '0);
    for (int i = 0; i < 3; i++) begin
      side0.pneg[i] = pos0_q[i][31];
      side0.ap[i]   = pos0_q[i][31] ? 32'(-pos0_q[i]) : pos0_q[i];
    end
  end

  // stage 1: squares
  logic             v1_q;
  logic [2:0][63:0] sq1_q;
  scrs_pkg::side_t  side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq1_q[0] <= side0.ap[0] * side0.ap[0];
    sq1_q[1] <= side0.ap[1] * side0.ap[1];
    sq1_q[2] <= side0.sphere ? side0.ap[2] * side0.ap[2] : 64'd0;
    side1_q  <= side0;
  end

  // stage 2: sum of squares (below 2^64)
  logic            v2_q;
  logic [63:0]     sum2_q;
  scrs_pkg::side_t side2_q, side2_d;
  logic [63:0]     sum1;

  assign sum1 = sq1_q[0] + sq1_q[1] + sq1_q[2];

  always_comb begin
    side2_d      = side1_q;
    side2_d.zero = (sum1 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum2_q  <= sum1;
    side2_q <= side2_d;
  end

  // square root
  logic                       vs;
  logic [scrs_pkg::RootW-1:0] root;
  scrs_pkg::side_t            sides;

  scrs_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .radicand_i  (sum2_q),
    .side_i      (side2_q),
    .out_valid_o (vs),
    .root_o      (root),
    .side_o      (sides)
  );

  // stage A: radius difference and gain select
  logic [32:0]     diff;
  logic            va_q;
  logic [30:0]     ga_q;
  logic [31:0]     ada_q, na_q;
  scrs_pkg::side_t sidea_q, sidea_d;

  assign diff = {2'b00, radius_q} - {1'b0, root};

  always_comb begin
    sidea_d      = sides;
    sidea_d.dneg = diff[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    ga_q    <= (root < {1'b0, radius_q}) ? push_q : pull_q;
    ada_q   <= diff[32] ? 32'(-diff) : diff[31:0];
    na_q    <= root;
    sidea_q <= sidea_d;
  end

  // stage B: gain times |R - n|, below 2^63
  logic            vb_q;
  logic [62:0]     mb_q;
  logic [31:0]     nb_q;
  scrs_pkg::side_t sideb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mb_q    <= ga_q * ada_q;
    nb_q    <= na_q;
    sideb_q <= sidea_q;
  end

  // stage C: split products with |p|
  logic             vc_q;
  logic [2:0][63:0] loc_q;
  logic [2:0][62:0] hic_q;
  logic [31:0]      nc_q;
  scrs_pkg::side_t  sidec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      loc_q[i] <= mb_q[31:0] * sideb_q.ap[i];
      hic_q[i] <= mb_q[62:32] * sideb_q.ap[i];
    end
    nc_q    <= nb_q;
    sidec_q <= sideb_q;
  end

  // stage D: dividend = hi + lo/2^32, below 2^63
  logic                           vd_q;
  logic [2:0][scrs_pkg::NumW-1:0] numd_q;
  logic [31:0]                    nd_q;
  scrs_pkg::side_t                sided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      numd_q[i] <= hic_q[i] + {31'd0, loc_q[i][63:32]};
    end
    nd_q    <= nc_q;
    sided_q <= sidec_q;
  end

  // divider; a zero distance gives a junk quotient that is ignored below
  logic                           vq;
  logic [2:0][scrs_pkg::NumW-1:0] quot;
  scrs_pkg::side_t                sideq;

  scrs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vd_q),
    .num_i       (numd_q),
    .den_i       (nd_q),
    .side_i      (sided_q),
    .out_valid_o (vq),
    .quot_o      (quot),
    .side_o      (sideq)
  );

  // final: signed add with saturation, or the derivative passed through unchanged
  logic [2:0][31:0] res_d;
  logic             clip_d;

  always_comb begin
    logic [63:0] delta;
    logic [64:0] s;
    logic        hi_clip, lo_clip;
    clip_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      delta = (sideq.dneg != sideq.pneg[i]) ? 64'(-{1'b0, quot[i]}) : {1'b0, quot[i]};
      s = {{33{sideq.deriv[i][31]}}, sideq.deriv[i]} + {delta[63], delta};
      hi_clip = !s[64] && (s[63:31] != '0);
      lo_clip = s[64] && (s[63:31] != '1);
      if (sideq.zero || (i == 2 && !sideq.sphere)) begin
        res_d[i] = sideq.deriv[i];
      end else if (hi_clip) begin
        res_d[i] = 32'h7FFF_FFFF;
        clip_d   = 1'b1;
      end else if (lo_clip) begin
        res_d[i] = 32'h8000_0000;
        clip_d   = 1'b1;
      end else begin
        res_d[i] = s[31:0];
      end
    end
  end

  logic             strobe_q, sphere_q, zero_q, sat_q;
  logic [2:0][31:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      sphere_q <= 1'b0;
      zero_q   <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      strobe_q <= vq;
      sphere_q <= vq && sideq.sphere;
      zero_q   <= vq && sideq.zero;
      sat_q    <= vq && clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_strobe_o    = strobe_q;
  assign new_deriv_x_o   = res_q[0];
  assign new_deriv_y_o   = res_q[1];
  assign new_deriv_z_o   = res_q[2];
  assign on_sphere_o     = sphere_q;
  assign zero_distance_o = zero_q;
  assign saturated_o     = sat_q;

  `SCRS_ASSERT(a_zero_no_clip, zero_distance_o |-> !saturated_o)
  `SCRS_ASSERT_NEVER(a_flags_without_strobe, !out_strobe_o && (on_sphere_o || zero_distance_o || saturated_o))
endmodule
